/* design/crcsw_pkg.sv */
// Shared types, constants and the CRC byte step for the CRC-32 engine with skip window.
// No dependencies; every other design file imports this package.
`default_nettype none

package crcsw_pkg;

  // Width of the message byte counter.
  localparam int INDEX_WIDTH = 16;

  // Width of each window register.
  localparam int CFG_WIDTH = 16;

  // Window compare width: wide enough for the index and for offset + size without wrap.
  localparam int CMP_WIDTH = ((INDEX_WIDTH > CFG_WIDTH) ? INDEX_WIDTH : CFG_WIDTH) + 1;

  // APB address and data widths.
  localparam int ADDR_WIDTH = 3;
  localparam int DATA_WIDTH = 32;

  // CRC-32 (reflected, IEEE 802.3).
  localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
  localparam logic [31:0] CRC_XOROUT = 32'hFFFF_FFFF;

  // Register indexes, taken from address bit 2.
  typedef enum logic {
    REG_WIN_BASE = 1'b0,
    REG_WIN_LEN  = 1'b1
  } crcsw_reg_t;

  // Window settings passed from the register file to the datapath.
  typedef struct packed {
    logic [CFG_WIDTH-1:0] win_base;
    logic [CFG_WIDTH-1:0] win_len;
  } crcsw_cfg_t;

  // One reflected CRC-32 byte update, eight bit steps of shift and conditional XOR.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* design/crcsw_regs.sv */
// APB register file holding the skip window offset and size.
// Depends on crcsw_pkg for widths, register indexes and the config struct.
`default_nettype none

module crcsw_regs import crcsw_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_WIDTH-1:0] paddr,
  input  wire logic [DATA_WIDTH-1:0] pwdata,
  output logic      [DATA_WIDTH-1:0] prdata,
  output logic                       pready,
  output crcsw_cfg_t                 cfg
);

  crcsw_reg_t reg_sel;
  logic       wr_en;

  assign reg_sel = crcsw_reg_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Write the selected register; upper data bits are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.win_base <= '0;
      cfg.win_len  <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_WIN_BASE: cfg.win_base <= pwdata[CFG_WIDTH-1:0];
        REG_WIN_LEN:  cfg.win_len  <= pwdata[CFG_WIDTH-1:0];
        default:      cfg.win_len  <= cfg.win_len;
      endcase
    end
  end

  // Read back the selected register, zero extended.
  always_comb begin
    unique case (reg_sel)
      REG_WIN_BASE: prdata = DATA_WIDTH'(cfg.win_base);
      REG_WIN_LEN:  prdata = DATA_WIDTH'(cfg.win_len);
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* design/crcsw_core.sv */
// Byte datapath: input holding register, window test, CRC byte step, result register.
// Depends on crcsw_pkg for the CRC step, constants and the config struct.
`default_nettype none

module crcsw_core import crcsw_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire crcsw_cfg_t cfg,
  input  wire logic       byte_valid,
  output logic            byte_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output logic            crc_valid,
  input  wire logic       crc_ready,
  output logic [31:0]     crc_value
);

  localparam logic [INDEX_WIDTH-1:0] INDEX_MAX = {INDEX_WIDTH{1'b1}};

  // Input holding register.
  logic       hold_valid;
  logic [7:0] hold_data;
  logic       hold_last;

  // Message state.
  logic [31:0]            running_crc;
  logic [31:0]            running_crc_next;
  logic [INDEX_WIDTH-1:0] byte_index;
  logic [INDEX_WIDTH-1:0] byte_index_next;

  logic                 consume;
  logic                 in_window;
  logic [CMP_WIDTH-1:0] idx_ext;
  logic [CMP_WIDTH-1:0] win_start;
  logic [CMP_WIDTH-1:0] win_end;
  logic [31:0]          crc_step;

  // Retire the held byte unless it is a last byte blocked by an untaken result.
  assign consume    = hold_valid && (!hold_last || !crc_valid || crc_ready);
  assign byte_ready = !hold_valid || consume;

  // Capture a new transaction whenever the holding register frees up.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (byte_ready) begin
      hold_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ready && byte_valid) begin
      hold_data <= data_byte;
      hold_last <= last_byte;
    end
  end

  // Test the current index against the window, end computed without wrap.
  assign idx_ext   = CMP_WIDTH'(byte_index);
  assign win_start = CMP_WIDTH'(cfg.win_base);
  assign win_end   = CMP_WIDTH'(cfg.win_base) + CMP_WIDTH'(cfg.win_len);
  assign in_window = (idx_ext >= win_start) && (idx_ext < win_end);

  assign crc_step = in_window ? running_crc : crc_byte(running_crc, hold_data);

  // Advance the CRC and index; restart both after the last byte.
  always_comb begin
    running_crc_next = running_crc;
    byte_index_next  = byte_index;
    if (consume) begin
      if (hold_last) begin
        running_crc_next = CRC_INIT;
        byte_index_next  = '0;
      end else begin
        running_crc_next = crc_step;
        if (byte_index != INDEX_MAX) begin
          byte_index_next = byte_index + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= CRC_INIT;
      byte_index  <= '0;
    end else begin
      running_crc <= running_crc_next;
      byte_index  <= byte_index_next;
    end
  end

  // Load the result register on a last byte, drop it once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_valid <= 1'b0;
    end else if (consume && hold_last) begin
      crc_valid <= 1'b1;
    end else if (crc_ready) begin
      crc_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && hold_last) begin
      crc_value <= crc_step ^ CRC_XOROUT;
    end
  end

`ifndef SYNTHESIS
  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    (consume && hold_last) |=> (running_crc == CRC_INIT && byte_index == '0))
    else $error("state not restarted after last byte");

  a_last_loads_result: assert property (@(posedge clk) disable iff (rst)
    (consume && hold_last) |=> crc_valid)
    else $error("last byte did not produce a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && hold_last && crc_valid && !crc_ready) |-> !consume)
    else $error("untaken result overwritten");

  a_index_monotonic: assert property (@(posedge clk) disable iff (rst)
    (consume && !hold_last) |=> (byte_index != '0 && byte_index >= $past(byte_index)))
    else $error("byte index did not advance or saturate");
`endif

endmodule

`default_nettype wire

/* design/crc32_with_skip_window.sv */
// Top level of the byte-serial CRC-32 engine with an excluded byte window.
// Depends on crcsw_pkg, crcsw_regs and crcsw_core.
`default_nettype none

// Reflected CRC-32 (poly 0xEDB88320, init and final XOR all ones) over a message fed one
// byte per transaction, with last_byte marking the final byte. Bytes whose index falls in
// the window [offset, offset + size) are left out of the CRC; the byte index saturates
// at its maximum. Each last byte yields one crc_value transaction; other bytes yield none.
// The engine takes one byte every cycle while no last byte waits: a byte passes through
// an input holding register and one CRC byte step, and a last byte's CRC lands in a
// single result register, flagged by crc_valid. A last byte waits in the holding
// register only while that result register holds a CRC not yet taken. Program the window
// over APB (offset at 0x0, size at 0x4) while no message is in flight.
module crc32_with_skip_window import crcsw_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_WIDTH-1:0] paddr,
  input  wire logic [DATA_WIDTH-1:0] pwdata,
  output logic      [DATA_WIDTH-1:0] prdata,
  output logic                       pready,
  input  wire logic                  byte_valid,
  output logic                       byte_ready,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  last_byte,
  output logic                       crc_valid,
  input  wire logic                  crc_ready,
  output logic      [31:0]           crc_value
);

  crcsw_cfg_t cfg;

  crcsw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  crcsw_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .crc_valid  (crc_valid),
    .crc_ready  (crc_ready),
    .crc_value  (crc_value)
  );

endmodule

`default_nettype wire
